// ----- rtl/arpc_pkg.sv -----
// Shared types and constants for the ARP cache and responder.
// Used by the interfaces, the cache cells, the sequencer and the checker.
`timescale 1ns / 1ps

package arpc_pkg;

  // Cell index width covers the largest supported cache of 256 entries.
  localparam int unsigned IDX_W = 8;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_PACKET = 2'd1;
  localparam logic [1:0] OP_SEND   = 2'd2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd1;

  localparam logic [15:0] ARP_MIN_LEN    = 16'd28;
  localparam logic [15:0] ARP_HTYPE_ETH  = 16'd1;
  localparam logic [15:0] ARP_PTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  ARP_HLEN       = 8'd6;
  localparam logic [7:0]  ARP_PLEN       = 8'd4;
  localparam logic [15:0] ARP_OPC_REQ    = 16'd1;

  localparam logic [1:0]  SEND_NONE    = 2'd0;
  localparam logic [1:0]  SEND_REQUEST = 2'd1;
  localparam logic [1:0]  SEND_REPLY   = 2'd2;
  localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] query_address;
    logic [15:0] frame_length;
    logic [15:0] packet_hw_type;
    logic [15:0] packet_proto_type;
    logic [7:0]  packet_hw_len;
    logic [7:0]  packet_proto_len;
    logic [15:0] packet_opcode;
    logic [47:0] packet_sender_mac;
    logic [31:0] packet_sender_ip;
    logic [31:0] packet_target_ip;
  } req_t;

  typedef struct packed {
    logic        lookup_hit;
    logic [47:0] lookup_mac;
    logic        packet_accepted;
    logic        send_valid;
    logic [1:0]  send_opcode;
    logic [47:0] send_dest_mac;
    logic [47:0] send_target_mac;
    logic [31:0] send_target_ip;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [31:0]      addr;
    logic             hit;
    logic [47:0]      mac;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } probe_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      addr;
    logic [47:0]      mac;
  } wr_t;

endpackage

// ----- rtl/arpc_if.sv -----
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on arpc_pkg for the payload types.
`timescale 1ns / 1ps

interface arpc_req_if;
  logic          valid;
  logic          ready;
  arpc_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface arpc_rsp_if;
  logic          valid;
  logic          ready;
  arpc_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface arpc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [arpc_pkg::CFG_IDX_W-1:0]   index;
  logic [47:0]                      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/arpc_cell.sv -----
// One cache entry: holds an address pair, tags a passing probe and takes writes.
// Depends on arpc_pkg for the probe and write types.
`timescale 1ns / 1ps

module arpc_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  arpc_pkg::probe_t probe_i,
  output arpc_pkg::probe_t probe_o,
  input  arpc_pkg::wr_t    wr_i
);
  import arpc_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic        valid_q;
  logic [31:0] addr_q;
  logic [47:0] mac_q;
  probe_t      probe_d, probe_q;
  logic        wr_sel;

  assign wr_sel = wr_i.en && (wr_i.idx == MyIdx);

  always_comb begin
    probe_d = probe_i;
    if (probe_i.valid) begin
      if (!probe_i.hit && valid_q && (addr_q == probe_i.addr)) begin
        probe_d.hit     = 1'b1;
        probe_d.mac     = mac_q;
        probe_d.hit_idx = MyIdx;
      end
      if (!probe_i.free && !valid_q) begin
        probe_d.free     = 1'b1;
        probe_d.free_idx = MyIdx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
      if (wr_sel) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      addr_q <= wr_i.addr;
      mac_q  <= wr_i.mac;
    end
  end

  assign probe_o = probe_q;

endmodule

// ----- rtl/arpc_ctrl.sv -----
// Sequencer: takes requests and register writes, launches probes down the cell
// row, builds results and issues cache writes. Depends on arpc_pkg, arpc_if.
`timescale 1ns / 1ps

module arpc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  arpc_req_if.sink         req_i,
  arpc_rsp_if.source       rsp_o,
  arpc_cfg_if.sink         cfg_i,
  output arpc_pkg::probe_t probe_o,
  input  arpc_pkg::probe_t probe_i,
  output arpc_pkg::wr_t    wr_o
);
  import arpc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]  state_q, state_d;
  req_t        item_q;
  rsp_t        res_d, res_q;
  rsp_t        out_q;
  logic        out_valid_q;
  wr_t         wr_d, wr_q;
  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;
  logic        accept;
  logic        done;
  logic        load_out;
  logic        pkt_ok;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign done        = (state_q == ST_SCAN) && probe_i.valid;
  assign load_out    = (state_q == ST_HOLD) && (!out_valid_q || rsp_o.ready);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    probe_o       = '0;
    probe_o.valid = accept;
    probe_o.addr  = (req_i.payload.operation == OP_PACKET) ?
                    req_i.payload.packet_sender_ip : req_i.payload.query_address;
  end

  assign pkt_ok = (item_q.frame_length >= ARP_MIN_LEN) &&
                  (item_q.packet_hw_type == ARP_HTYPE_ETH) &&
                  (item_q.packet_proto_type == ARP_PTYPE_IPV4) &&
                  (item_q.packet_hw_len == ARP_HLEN) &&
                  (item_q.packet_proto_len == ARP_PLEN);

  always_comb begin
    res_d   = '0;
    wr_d    = '0;
    wr_d.idx  = probe_i.hit ? probe_i.hit_idx : (probe_i.free ? probe_i.free_idx : '0);
    wr_d.addr = item_q.packet_sender_ip;
    wr_d.mac  = item_q.packet_sender_mac;
    case (item_q.operation)
      OP_LOOKUP: begin
        res_d.lookup_hit = probe_i.hit;
        res_d.lookup_mac = probe_i.hit ? probe_i.mac : '0;
      end
      OP_PACKET: begin
        if (pkt_ok) begin
          res_d.packet_accepted = 1'b1;
          wr_d.en = done;
          if ((item_q.packet_opcode == ARP_OPC_REQ) &&
              (item_q.packet_target_ip == own_ip_q)) begin
            res_d.send_valid      = 1'b1;
            res_d.send_opcode     = SEND_REPLY;
            res_d.send_dest_mac   = item_q.packet_sender_mac;
            res_d.send_target_mac = item_q.packet_sender_mac;
            res_d.send_target_ip  = item_q.packet_sender_ip;
          end
        end
      end
      OP_SEND: begin
        res_d.send_valid      = 1'b1;
        res_d.send_opcode     = SEND_REQUEST;
        res_d.send_dest_mac   = MAC_BCAST;
        res_d.send_target_mac = '0;
        res_d.send_target_ip  = item_q.query_address;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (done) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      wr_q        <= '0;
      own_ip_q    <= '0;
      own_mac_q   <= '0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_OWN_IP:  own_ip_q  <= cfg_i.data[31:0];
          CFG_OWN_MAC: own_mac_q <= cfg_i.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= req_i.payload;
    if (done) res_q <= res_d;
    if (load_out) out_q <= res_q;
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;
  assign wr_o          = wr_q;

endmodule

// ----- rtl/arp_cache_and_responder.sv -----
// ARP cache and responder: one request in, one result out. Each request sends a
// probe down a row of CACHE_ENTRIES cells, one cell per cycle; the sequencer
// registers the result when the probe leaves the last cell and loads it into the
// output register once that register is free. The next request is taken once the
// result has been loaded into the output register, also while it still waits to
// be taken. A received packet that passes the format checks updates the cache at
// the edge that ends the cycle after its probe returns from the last cell. The
// cache is empty after reset; own_ip (index 0) and own_mac (index 1) reset to
// zero; the user must write them only while idle, which the block does not enforce.
// Depends on arpc_pkg, arpc_if, arpc_cell and arpc_ctrl.
`timescale 1ns / 1ps

module arp_cache_and_responder #(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  arpc_req_if.sink   req_i,
  arpc_rsp_if.source rsp_o,
  arpc_cfg_if.sink   cfg_i
);
  import arpc_pkg::*;

  probe_t chain [CACHE_ENTRIES+1];
  wr_t    wr;

  arpc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .cfg_i   (cfg_i),
    .probe_o (chain[0]),
    .probe_i (chain[CACHE_ENTRIES]),
    .wr_o    (wr)
  );

  for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
    arpc_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .probe_i (chain[k]),
      .probe_o (chain[k+1]),
      .wr_i    (wr)
    );
  end

endmodule

// ----- rtl/arpc_checker.sv -----
// Port-level checks on the ARP cache and responder, bound to the top level.
// Depends on arpc_pkg for the result type.
`timescale 1ns / 1ps

module arpc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input arpc_pkg::rsp_t rsp_payload_i
);
  import arpc_pkg::*;

  logic [1:0] pending_q;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (req_fire && !rsp_fire) begin
      pending_q <= pending_q + 2'd1;
    end else if (rsp_fire && !req_fire) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_ready_i)
    else $error("request taken while another is in the cell row");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_fire |-> pending_q != 2'd0)
    else $error("result without a pending request");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> pending_q != 2'd2)
    else $error("more than two requests in flight");

endmodule

bind arp_cache_and_responder arpc_checker u_arpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);

// ----- sim/tb_arp_cache_and_responder.sv -----
`timescale 1ns / 1ps
// Self-checking bench for arp_cache_and_responder: lookups, parsed ARP packets and send
// requests go in over the request channel, each result is checked against a model of the
// cache. Depends on arpc_pkg and the channel interfaces in arpc_if.

module tb_arp_cache_and_responder;
  import arpc_pkg::*;

  localparam int unsigned ENTRIES = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [15:0] ARP_OPC_REPLY = 16'd2;
  localparam int unsigned QUIET_TAIL = 120;
  localparam int unsigned POOL_SIZE = 22;
  localparam int unsigned PHASE_ITEMS = 340;

  typedef enum logic {STEP_REQUEST, STEP_REG_WRITE} step_kind_e;

  typedef struct {
    step_kind_e           kind;
    req_t                 req;
    logic [CFG_IDX_W-1:0] idx;
    logic [47:0]          data;
  } arp_step_t;

  logic clk_i;
  logic rst_ni;

  arpc_req_if req_ch();
  arpc_rsp_if rsp_ch();
  arpc_cfg_if cfg_ch();

  arp_cache_and_responder #(.CACHE_ENTRIES(ENTRIES)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  arp_step_t   arp_steps[$];
  rsp_t        results_due[$];
  int unsigned mismatches;
  logic        quiet_tail;

  // model state
  logic [31:0] station_ip;
  logic [47:0] station_mac;
  logic [31:0] cache_ip [ENTRIES];
  logic [47:0] cache_mac [ENTRIES];
  bit          cache_live [ENTRIES];

  // stimulus state
  logic [31:0] gen_own_ip;
  logic [31:0] ip_pool [POOL_SIZE];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void learn_sender(logic [31:0] ip, logic [47:0] mac);
    int slot;
    slot = -1;
    for (int k = 0; k < ENTRIES; k++)
      if (slot < 0 && cache_live[k] && cache_ip[k] == ip) slot = k;
    for (int k = 0; k < ENTRIES; k++)
      if (slot < 0 && !cache_live[k]) slot = k;
    if (slot < 0) slot = 0;
    cache_ip[slot] = ip;
    cache_mac[slot] = mac;
    cache_live[slot] = 1'b1;
  endfunction

  function automatic rsp_t resolve_arp_request(req_t r);
    rsp_t res;
    res = '0;
    case (r.operation)
      OP_LOOKUP: begin
        for (int k = ENTRIES - 1; k >= 0; k--)
          if (cache_live[k] && cache_ip[k] == r.query_address) begin
            res.lookup_hit = 1'b1;
            res.lookup_mac = cache_mac[k];
          end
      end
      OP_PACKET: begin
        if (r.frame_length >= ARP_MIN_LEN && r.packet_hw_type == ARP_HTYPE_ETH &&
            r.packet_proto_type == ARP_PTYPE_IPV4 && r.packet_hw_len == ARP_HLEN &&
            r.packet_proto_len == ARP_PLEN) begin
          res.packet_accepted = 1'b1;
          learn_sender(r.packet_sender_ip, r.packet_sender_mac);
          if (r.packet_opcode == ARP_OPC_REQ && r.packet_target_ip == station_ip) begin
            res.send_valid      = 1'b1;
            res.send_opcode     = SEND_REPLY;
            res.send_dest_mac   = r.packet_sender_mac;
            res.send_target_mac = r.packet_sender_mac;
            res.send_target_ip  = r.packet_sender_ip;
          end
        end
      end
      OP_SEND: begin
        res.send_valid      = 1'b1;
        res.send_opcode     = SEND_REQUEST;
        res.send_dest_mac   = MAC_BCAST;
        res.send_target_mac = '0;
        res.send_target_ip  = r.query_address;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void load_station_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
    case (idx)
      CFG_OWN_IP:  station_ip = data[31:0];
      CFG_OWN_MAC: station_mac = data;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      if (mismatches < 10) $display("mismatch %s: expected %h, got %h", what, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return w[47:0];
    endcase
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic req_t noise_request();
    req_t r;
    r.operation         = 2'($urandom);
    r.query_address     = $urandom;
    r.frame_length      = 16'($urandom);
    r.packet_hw_type    = 16'($urandom);
    r.packet_proto_type = 16'($urandom);
    r.packet_hw_len     = 8'($urandom);
    r.packet_proto_len  = 8'($urandom);
    r.packet_opcode     = 16'($urandom);
    r.packet_sender_mac = {16'($urandom), $urandom};
    r.packet_sender_ip  = $urandom;
    r.packet_target_ip  = $urandom;
    return r;
  endfunction

  function automatic req_t good_packet(logic [15:0] opc, logic [31:0] sip,
                                       logic [47:0] smac, logic [31:0] tip);
    req_t r;
    r = noise_request();
    r.operation         = OP_PACKET;
    r.frame_length      = ($urandom_range(0, 3) == 0) ? ARP_MIN_LEN :
                          16'($urandom_range(28, 65535));
    r.packet_hw_type    = ARP_HTYPE_ETH;
    r.packet_proto_type = ARP_PTYPE_IPV4;
    r.packet_hw_len     = ARP_HLEN;
    r.packet_proto_len  = ARP_PLEN;
    r.packet_opcode     = opc;
    r.packet_sender_mac = smac;
    r.packet_sender_ip  = sip;
    r.packet_target_ip  = tip;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    logic [15:0] opc;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: opc = ARP_OPC_REQ;
        6, 7, 8:          opc = ARP_OPC_REPLY;
        default:          opc = 16'($urandom);
      endcase
      r = good_packet(opc, pick_ip(), rand_mac(),
                      ($urandom_range(0, 1) == 0) ? gen_own_ip : pick_ip());
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: r.frame_length = 16'($urandom_range(0, 27));
          1: r.packet_hw_type ^= 16'($urandom_range(1, 65535));
          2: r.packet_proto_type ^= 16'($urandom_range(1, 65535));
          3: r.packet_hw_len ^= 8'($urandom_range(1, 255));
          default: r.packet_proto_len ^= 8'($urandom_range(1, 255));
        endcase
      end
    end else if (pick < 80) begin
      r = noise_request();
      r.operation = OP_LOOKUP;
      r.query_address = pick_ip();
    end else if (pick < 95) begin
      r = noise_request();
      r.operation = OP_SEND;
      r.query_address = pick_ip();
    end else begin
      r = noise_request();
    end
    return r;
  endfunction

  function automatic void push_request(req_t r);
    arp_step_t s;
    s.kind = STEP_REQUEST;
    s.req  = r;
    s.idx  = '0;
    s.data = '0;
    arp_steps.push_back(s);
  endfunction

  function automatic void push_reg_write(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
    arp_step_t s;
    s.kind = STEP_REG_WRITE;
    s.req  = '0;
    s.idx  = idx;
    s.data = data;
    if (idx == CFG_OWN_IP) gen_own_ip = data[31:0];
    arp_steps.push_back(s);
  endfunction

  // request driver and register writer
  int unsigned gap_left;
  int unsigned drv_mode_left;
  bit          drv_idling;

  always @(posedge clk_i) begin
    arp_step_t nxt;
    logic      req_busy;
    logic      cfg_busy;
    logic      req_v;
    logic      cfg_v;
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      cfg_ch.valid <= 1'b0;
      quiet_tail <= 1'b0;
      gap_left = 0;
      drv_mode_left = 0;
      drv_idling = 1'b1;
    end else begin
      req_busy = req_ch.valid && !req_ch.ready;
      cfg_busy = cfg_ch.valid && !cfg_ch.ready;
      if (req_ch.valid && req_ch.ready) results_due.push_back(resolve_arp_request(req_ch.payload));
      if (cfg_ch.valid && cfg_ch.ready) load_station_reg(cfg_ch.index, cfg_ch.data);
      quiet_tail <= (arp_steps.size() < QUIET_TAIL);
      if (drv_mode_left == 0) begin
        drv_mode_left = $urandom_range(100, 400);
        drv_idling = ($urandom_range(0, 2) != 0);
      end else begin
        drv_mode_left--;
      end
      req_v = req_busy;
      cfg_v = cfg_busy;
      if (!req_busy && !cfg_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!quiet_tail && drv_idling && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 18) - 1;
        end else if (arp_steps.size() > 0) begin
          if (arp_steps[0].kind == STEP_REQUEST) begin
            nxt = arp_steps.pop_front();
            req_ch.payload <= nxt.req;
            req_v = 1'b1;
          end else if (results_due.size() == 0) begin
            // hold register writes until the block has drained
            nxt = arp_steps.pop_front();
            cfg_ch.index <= nxt.idx;
            cfg_ch.data <= nxt.data;
            cfg_v = 1'b1;
          end
        end
      end
      req_ch.valid <= req_v;
      cfg_ch.valid <= cfg_v;
    end
  end

  // result monitor
  int unsigned stall_left;
  int unsigned mon_mode_left;
  bit          mon_idling;

  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    logic rdy;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
      mon_mode_left = 0;
      mon_idling = 1'b1;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.payload;
        if (results_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %p", got);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("lookup_hit", got.lookup_hit, want.lookup_hit);
          check_field("lookup_mac", got.lookup_mac, want.lookup_mac);
          check_field("packet_accepted", got.packet_accepted, want.packet_accepted);
          check_field("send_valid", got.send_valid, want.send_valid);
          check_field("send_opcode", got.send_opcode, want.send_opcode);
          check_field("send_dest_mac", got.send_dest_mac, want.send_dest_mac);
          check_field("send_target_mac", got.send_target_mac, want.send_target_mac);
          check_field("send_target_ip", got.send_target_ip, want.send_target_ip);
        end
      end
      if (mon_mode_left == 0) begin
        mon_mode_left = $urandom_range(100, 400);
        mon_idling = ($urandom_range(0, 2) != 0);
      end else begin
        mon_mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!quiet_tail && mon_idling && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      rsp_ch.ready <= rdy;
    end
  end

  initial begin
    #5_000_000;
    $display("arp_cache_and_responder verification failed");
    $finish;
  end

  initial begin
    req_t        r;
    logic [31:0] ip;
    logic [47:0] mac;
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
    mismatches = 0;
    quiet_tail = 1'b0;
    station_ip = '0;
    station_mac = '0;
    gen_own_ip = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      cache_ip[k] = '0;
      cache_mac[k] = '0;
      cache_live[k] = 1'b0;
    end
    ip_pool[0] = 32'h0000_0000;
    ip_pool[1] = 32'hFFFF_FFFF;
    ip_pool[2] = 32'hC0A8_0001;
    ip_pool[3] = 32'h0A00_0001;
    for (int k = 4; k < POOL_SIZE; k++) ip_pool[k] = $urandom;

    push_reg_write(CFG_OWN_IP, 48'h0000_C0A8_0001);
    push_reg_write(CFG_OWN_MAC, 48'h0200_0000_0001);

    // empty cache: address zero must miss
    r = noise_request();
    r.operation = OP_LOOKUP;
    r.query_address = '0;
    push_request(r);
    r = noise_request();
    r.operation = OP_SEND;
    r.query_address = '1;
    push_request(r);
    r.query_address = '0;
    push_request(r);
    r = noise_request();
    r.operation = OP_UNUSED;
    push_request(r);

    push_request(good_packet(ARP_OPC_REPLY, 32'h0A00_0001, 48'h1111_2222_3333, 32'h0A00_0001));
    r = noise_request();
    r.operation = OP_LOOKUP;
    r.query_address = 32'h0A00_0001;
    push_request(r);
    push_request(good_packet(ARP_OPC_REQ, 32'h0A00_0002, 48'h4444_5555_6666, 32'hC0A8_0001));
    push_request(good_packet(ARP_OPC_REQ, 32'h0A00_0003, 48'h7777_8888_9999, 32'h0A00_00FE));
    // refresh an existing entry
    push_request(good_packet(ARP_OPC_REPLY, 32'h0A00_0001, 48'hAAAA_BBBB_CCCC, 32'h0));
    push_request(r);

    // format rejects, each a request to own_ip that must not be answered
    r = good_packet(ARP_OPC_REQ, 32'h0A00_0004, 48'h0D0D_0D0D_0D0D, 32'hC0A8_0001);
    r.frame_length = 16'd27;
    push_request(r);
    r.frame_length = 16'hFFFF;
    r.packet_hw_type = 16'hFFFF;
    push_request(r);
    r.packet_hw_type = ARP_HTYPE_ETH;
    r.packet_proto_type = 16'h0806;
    push_request(r);
    r.packet_proto_type = ARP_PTYPE_IPV4;
    r.packet_hw_len = 8'd5;
    push_request(r);
    r.packet_hw_len = ARP_HLEN;
    r.packet_proto_len = 8'd3;
    push_request(r);
    r = noise_request();
    r.operation = OP_LOOKUP;
    r.query_address = 32'h0A00_0004;
    push_request(r);

    push_request(good_packet(16'hFFFF, 32'h0A00_0005, 48'h1234_5678_9ABC, 32'hC0A8_0001));
    r = good_packet(ARP_OPC_REQ, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 32'hC0A8_0001);
    r.frame_length = 16'hFFFF;
    push_request(r);
    r = noise_request();
    r.operation = OP_LOOKUP;
    r.query_address = '0;
    push_request(r);
    push_request(good_packet(ARP_OPC_REPLY, 32'hFFFF_FFFF, 48'h0, 32'h0));
    r.query_address = '1;
    push_request(r);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          ip = '0;
          mac = '0;
        end
        1: begin
          ip = '1;
          mac = '1;
        end
        default: begin
          ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
          mac = rand_mac();
        end
      endcase
      push_reg_write(CFG_OWN_IP, {(ph > 1) ? 16'($urandom) : 16'h0, ip});
      push_reg_write(CFG_OWN_MAC, mac);
      if (ph > 1) begin
        push_reg_write(CFG_SPARE_A, rand_mac());
        push_reg_write(CFG_SPARE_B, rand_mac());
      end
      if (ph == 0) push_request(good_packet(ARP_OPC_REQ, 32'h0A00_0006, 48'h0, 32'h0));
      repeat (PHASE_ITEMS) push_request(random_request());
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (arp_steps.size() > 0 || req_ch.valid || cfg_ch.valid || results_due.size() > 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("arp_cache_and_responder verification clean");
    end else begin
      $display("arp_cache_and_responder verification failed");
    end
    $finish;
  end

endmodule
